/* design/mavg_pkg.sv */
// Shared types and fixed widths for the moving average block.
// No dependencies; used by moving_average_warmup, mavg_checker and tb_top.
package mavg_pkg;

  localparam int WIN_W  = 7;
  localparam int CNT_W  = 7;
  localparam int FRAC_W = 8;
  localparam int AVG_W  = 24;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

/* design/moving_average_warmup.sv */
// Boxcar moving average with warm-up: sample ring, running sum and bit-serial divider.
// Depends on mavg_pkg.
//
// Each item gives one result, floor(sum * 256 / n), where n is the number of
// samples seen in the current series until the window has filled, then the
// window length. An accepted item first updates the sum and ring, then the
// restoring divider produces one quotient bit per cycle, and then the result
// is loaded into the output register when it is free or its result is taken;
// in_stall stays high until that load, so the next item waits until then.
// The output register lets a new item enter while the previous result is
// still waiting to be taken. Writing window_length clears the sum and fill
// count; a zero length acts as 1, and lengths above MAX_WINDOW saturate.
module moving_average_warmup #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [SAMPLE_BITS-1:0]       in_sample,
  input  logic                         in_series_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mavg_pkg::AVG_W-1:0]   out_average,
  input  logic                         cfg_wr_en,
  input  logic [mavg_pkg::WIN_W-1:0]   cfg_wr_data
);

  localparam int WIN_MAX = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WIN_MAX);
  localparam int DIV_W   = SUM_W + mavg_pkg::FRAC_W;
  localparam int BCNT_W  = $clog2(DIV_W + 1);
  localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int AW      = PTR_W + 1;
  localparam int EXT_W   = (DIV_W > mavg_pkg::AVG_W) ? DIV_W : mavg_pkg::AVG_W;
  localparam logic [mavg_pkg::WIN_W-1:0] WIN_CAP = mavg_pkg::WIN_W'(WIN_MAX);
  localparam logic [AW-1:0]    DEPTH_A  = AW'(MAX_WINDOW);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);

  mavg_pkg::state_t state_r, state_nxt;

  logic [mavg_pkg::WIN_W-1:0] win_r;
  logic [mavg_pkg::CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0]           sum_r;
  logic [PTR_W-1:0]           wp_r;
  logic [SAMPLE_BITS-1:0]     ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0]     rd_data_r;
  logic [SAMPLE_BITS-1:0]     smp_r;
  logic                       self_r;
  logic                       sub_pend_r;
  logic [DIV_W-1:0]           div_q_r;
  logic [mavg_pkg::CNT_W-1:0] rem_r;
  logic [mavg_pkg::CNT_W-1:0] dvsr_r;
  logic [BCNT_W-1:0]          bit_cnt_r;
  logic                       out_valid_r;
  logic [mavg_pkg::AVG_W-1:0] out_average_r;

  logic                       in_acc;
  logic                       out_load;
  logic [mavg_pkg::WIN_W-1:0] win_eff;
  logic [mavg_pkg::CNT_W-1:0] cnt_base;
  logic [mavg_pkg::CNT_W-1:0] cnt_new;
  logic [SUM_W-1:0]           sum_new;
  logic [mavg_pkg::WIN_W-1:0] back;
  logic [AW-1:0]              old_tmp;
  logic [AW-1:0]              old_wrap;
  logic [PTR_W-1:0]           oldest;
  logic [SAMPLE_BITS-1:0]     sub_val;
  logic [mavg_pkg::CNT_W:0]   rem_sh;
  logic                       q_bit;
  logic [mavg_pkg::CNT_W:0]   rem_diff;
  logic [EXT_W-1:0]           q_ext;

  always_comb begin
    if (win_r == '0) begin
      win_eff = mavg_pkg::WIN_W'(1);
    end else if (win_r > WIN_CAP) begin
      win_eff = WIN_CAP;
    end else begin
      win_eff = win_r;
    end
  end

  assign cnt_base = in_series_start ? '0 : cnt_r;
  assign cnt_new  = (cnt_base < win_eff) ? cnt_base + 1'b1 : win_eff;
  assign sum_new  = (in_series_start ? '0 : sum_r) + SUM_W'(in_sample);

  assign back     = win_eff - 1'b1;
  assign old_tmp  = AW'(wp_r) + DEPTH_A - AW'(back);
  assign old_wrap = (old_tmp >= DEPTH_A) ? old_tmp - DEPTH_A : old_tmp;
  assign oldest   = old_wrap[PTR_W-1:0];
  assign sub_val  = self_r ? smp_r : rd_data_r;

  assign rem_sh   = {rem_r, div_q_r[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvsr_r};
  assign q_bit    = (rem_sh >= {1'b0, dvsr_r});
  assign q_ext    = EXT_W'(div_q_r);

  assign in_stall    = (state_r != mavg_pkg::ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      mavg_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = mavg_pkg::ST_DIV;
        end
      end
      mavg_pkg::ST_DIV: begin
        if (bit_cnt_r == BCNT_W'(1)) begin
          state_nxt = mavg_pkg::ST_DONE;
        end
      end
      mavg_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = mavg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mavg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mavg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= mavg_pkg::WIN_RESET;
      cnt_r       <= '0;
      sum_r       <= '0;
      wp_r        <= '0;
      sub_pend_r  <= 1'b0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
        cnt_r <= '0;
        sum_r <= '0;
      end else if (in_acc) begin
        cnt_r <= cnt_new;
        sum_r <= sum_new;
      end else if (sub_pend_r) begin
        sum_r <= sum_r - SUM_W'(sub_val);
      end
      if (in_acc) begin
        wp_r       <= (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
        sub_pend_r <= (cnt_new >= win_eff);
        bit_cnt_r  <= BCNT_W'(DIV_W);
      end else begin
        sub_pend_r <= 1'b0;
        if (state_r == mavg_pkg::ST_DIV) begin
          bit_cnt_r <= bit_cnt_r - 1'b1;
        end
      end
    end
  end

  // ring write at the slot, read of the oldest sample in the same cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ring_mem[wp_r] <= in_sample;
      rd_data_r      <= ring_mem[oldest];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r   <= in_sample;
      self_r  <= (back == '0);
      div_q_r <= {sum_new, mavg_pkg::FRAC_W'(0)};
      rem_r   <= '0;
      dvsr_r  <= cnt_new;
    end else if (state_r == mavg_pkg::ST_DIV) begin
      div_q_r <= {div_q_r[DIV_W-2:0], q_bit};
      rem_r   <= q_bit ? rem_diff[mavg_pkg::CNT_W-1:0] : rem_sh[mavg_pkg::CNT_W-1:0];
    end
    if (out_load) begin
      out_average_r <= q_ext[mavg_pkg::AVG_W-1:0];
    end
  end

  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == mavg_pkg::ST_DIV)
    else $error("accepted item did not start the divider");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mavg_pkg::ST_DIV |-> dvsr_r != '0 && bit_cnt_r != '0)
    else $error("divider running with zero divisor or spent bit count");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mavg_pkg::ST_IDLE |-> cnt_r <= win_eff)
    else $error("fill count above window length");

  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && state_r != mavg_pkg::ST_DONE |=> !out_valid)
    else $error("result repeated after being taken");

  a_sub_once: assert property (@(posedge clk) disable iff (!rst_n)
    sub_pend_r |=> !sub_pend_r)
    else $error("oldest sample subtracted twice");

endmodule

/* dv/mavg_checker.sv */
// Checker for moving_average_warmup. It watches the sample, result and window ports.
// It predicts each average, compares it with the result and counts mismatches.
// Depends on mavg_pkg.
module mavg_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [15:0]                          in_sample,
  input  logic                                 in_series_start,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [mavg_pkg::AVG_W-1:0]           out_average,
  input  logic                                 cfg_wr_en,
  input  logic [mavg_pkg::WIN_W-1:0]           cfg_wr_data,
  output int                                   fails,
  output int                                   owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 64;

  logic [15:0]                ring [RING_DEPTH];
  logic [21:0]                run_sum;
  logic [mavg_pkg::CNT_W-1:0] fill_cnt;
  logic [5:0]                 wr_ptr;
  logic [mavg_pkg::WIN_W-1:0] win_len;
  logic [mavg_pkg::AVG_W-1:0] expected_avgs [$];
  logic [mavg_pkg::AVG_W-1:0] want;
  int                         results_seen;

  function automatic logic [mavg_pkg::AVG_W-1:0] predict_average(input logic [15:0] smp,
                                                                 input logic start);
    logic [mavg_pkg::WIN_W-1:0] w;
    logic [mavg_pkg::WIN_W-1:0] divisor;
    logic [29:0]                scaled;
    logic [5:0]                 oldest;
    w = (win_len == 0) ? mavg_pkg::WIN_W'(1) :
        (win_len > RING_DEPTH) ? mavg_pkg::WIN_W'(RING_DEPTH) : win_len;
    if (start) begin
      run_sum = '0;
      fill_cnt = '0;
    end
    ring[wr_ptr] = smp;
    run_sum = run_sum + smp;
    if (fill_cnt < w) begin
      fill_cnt = fill_cnt + 1'b1;
    end else begin
      fill_cnt = w;
    end
    divisor = (fill_cnt < w) ? fill_cnt : w;
    scaled = {run_sum, {mavg_pkg::FRAC_W{1'b0}}} / divisor;
    if (fill_cnt >= w) begin
      oldest = wr_ptr - 6'(w - 1'b1);
      run_sum = run_sum - ring[oldest];
    end
    wr_ptr = wr_ptr + 1'b1;
    return scaled[mavg_pkg::AVG_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    if (fails < 200) begin
      $display("mavg_checker: %0t ns: %s", $time, what);
    end
    fails++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      win_len = mavg_pkg::WIN_RESET;
      run_sum = '0;
      fill_cnt = '0;
      wr_ptr = '0;
      expected_avgs.delete();
      owed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_avgs.size() == 0) begin
          report_mismatch($sformatf("unexpected average %h", out_average));
        end else begin
          want = expected_avgs.pop_front();
          if (out_average !== want) begin
            report_mismatch($sformatf("result %0d: average %h, expected %h",
                                      results_seen, out_average, want));
          end
        end
        results_seen++;
      end
      if (cfg_wr_en) begin
        win_len = cfg_wr_data;
        run_sum = '0;
        fill_cnt = '0;
      end
      if (in_valid && !in_stall) begin
        expected_avgs.insert(expected_avgs.size(),
                             predict_average(in_sample, in_series_start));
      end
      owed = expected_avgs.size();
    end
  end

endmodule

/* dv/tb_top.sv */
// Top of the moving_average_warmup testbench: clock, reset, sample and window stimulus, verdict.
// Depends on mavg_pkg, moving_average_warmup and mavg_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [15:0]                in_sample = '0;
  logic                       in_series_start = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [mavg_pkg::AVG_W-1:0] out_average;
  logic                       cfg_wr_en = 1'b0;
  logic [mavg_pkg::WIN_W-1:0] cfg_wr_data = '0;
  int                         fails;
  int                         owed;
  int                         send_idle_pct = 0;
  int                         recv_stall_pct = 0;

  always #5 clk = ~clk;

  moving_average_warmup DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_series_start (in_series_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  mavg_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_series_start (in_series_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .fails           (fails),
    .owed            (owed)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(input logic [15:0] smp, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    in_series_start <= start;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (owed != 0) @(negedge clk);
  endtask

  task automatic write_window(input logic [mavg_pkg::WIN_W-1:0] len);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [mavg_pkg::WIN_W-1:0] phase_win [12];
    logic [15:0]                smp;
    int                         start_pct;
    int                         kind;
    phase_win = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd2, 7'd17, 7'd40,
                  7'd64, 7'd100, mavg_pkg::WIN_W'($urandom_range(64, 1)),
                  mavg_pkg::WIN_W'($urandom_range(127))};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    repeat (4) send_item(16'hFFFF, 1'b0);
    repeat (3) send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b1);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h0000, 1'b1);
    send_item(16'hFFFF, 1'b1);
    drain_results();
    write_window(7'd1);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h0007, 1'b0);
    send_item(16'h0000, 1'b1);
    drain_results();
    write_window(7'd0);
    send_item(16'h1234, 1'b0);
    send_item(16'hFFFF, 1'b0);
    drain_results();
    write_window(7'd127);
    send_item(16'hFFFF, 1'b1);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h8000, 1'b0);

    for (int p = 0; p < 12; p++) begin
      drain_results();
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct = 35;
          recv_stall_pct = 35;
        end
      endcase
      write_window(phase_win[p]);
      start_pct = (p % 3 == 2) ? 15 : 2;
      for (int n = 0; n < 150; n++) begin
        kind = $urandom_range(9);
        case (kind)
          0: smp = 16'h0000;
          1: smp = 16'hFFFF;
          2: smp = 16'($urandom_range(255));
          default: smp = 16'($urandom);
        endcase
        send_item(smp, $urandom_range(99) < start_pct);
      end
    end

    drain_results();
    recv_stall_pct = 0;
    repeat (64) @(negedge clk);
    if (fails == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
design/mavg_pkg.sv
design/moving_average_warmup.sv
dv/mavg_checker.sv
dv/tb_top.sv
